### design/swmf_pkg.sv
// types and constants shared by the sliding window mean filter
// no dependencies
`default_nettype none
package swmf_pkg;

   localparam int WsW   = 4;
   localparam int ImwW  = 11;
   localparam int ImhW  = 13;
   localparam int HalfW = 3;
   localparam int SumW  = 16;
   localparam int CntW  = 8;
   localparam int PixW  = 8;
   localparam int RowW  = 12;
   localparam int ColW  = 10;
   localparam int CsrW  = 13;

   typedef enum logic [1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_SPARE        = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_FIN,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

### design/swmf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on swmf_pkg
`default_nettype none
module swmf_div
   import swmf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [SumW-1:0] dividend,
   input  wire logic [CntW-1:0] divisor,
   output logic                 done,
   output logic [PixW-1:0]      quotient
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [$clog2(SumW)-1:0]    step_ff, step_in;
   logic [CntW-1:0]            rem_ff, rem_in;
   logic [SumW-1:0]            quo_ff, quo_in;
   logic [CntW-1:0]            dsr_ff, dsr_in;
   logic [CntW:0]              rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, quo_ff[SumW-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = CntW'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CntW-1:0];
            quo_in = {quo_ff[SumW-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == ($clog2(SumW))'(SumW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[PixW-1:0];

endmodule
`default_nettype wire

### design/sliding_window_mean_filter_core.sv
// top level of the sliding window mean filter
// depends on swmf_pkg and swmf_div
//
// Box-filter mean over a square window with clipping at the image border. Pixels
// enter in raster order, one per request; each request yields at most one result,
// lagging the input by half*width+half pixels, and drain requests (tuser high)
// flush the pending results after the last pixel. For a request that yields a
// result, the n in-image window pixels (n up to 225) are summed through the
// single read port of the line memory, one pixel a cycle, then a bit-serial
// divider forms the mean. Requests that give no result leave the core idle. The
// result sits in an output register so the next request is taken while it waits.
// Config writes other than to the spare index restart the frame.
`default_nettype none
module sliding_window_mean_filter_core
   import swmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_WINDOW = 15
)(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [7:0]      req_tdata,   // pixel
   input  wire logic            req_tuser,   // opcode
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output logic [31:0]          rsp_tdata,   // mean, out_row, out_col, zero pad
   output logic                 rsp_tlast,   // frame_last
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [CsrW-1:0] csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int SB = $clog2(MAX_WINDOW + 1);
   localparam int AW = SB + CW;
   localparam int KW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int LW = EW + HalfW + 1;

   state_type state_ff, state_in;

   logic [WsW-1:0]  cfg_ws_ff;
   logic [ImwW-1:0] cfg_w_ff;
   logic [ImhW-1:0] cfg_h_ff;

   logic [RW-1:0] in_row_ff, in_row_in, emit_row_ff, emit_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, emit_col_ff, emit_col_in;
   logic [KW-1:0] kcnt_ff, kcnt_in;
   logic [RW-1:0] r_ff, r_in, r1_ff, r1_in;
   logic [CW-1:0] c_ff, c_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rdv_ff;

   logic [PixW-1:0] mem [2**AW];
   logic [PixW-1:0] mem_q_ff;
   logic [AW-1:0]   waddr, raddr;
   logic            mem_we;

   logic            rsp_vld_ff, rsp_vld_in;
   logic [31:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [EW-1:0]    eff_w;
   logic [RW-1:0]    eff_h;
   logic [HalfW-1:0] half;
   logic [WsW-1:0]   ws_clip;
   logic [LW-1:0]    lag;
   logic [RW:0]      row_hi;
   logic [EW:0]      col_hi;

   logic acc, push_ok, drain_ok, start_sum, csr_acc, ld, last_pos, clear_pos;
   logic div_done;
   logic [PixW-1:0] div_q;

   // effective configuration
   always_comb begin
      if (cfg_w_ff == '0) eff_w = EW'(1);
      else if (32'(cfg_w_ff) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
      else eff_w = EW'(cfg_w_ff);
      if (cfg_h_ff == '0) eff_h = RW'(1);
      else if (32'(cfg_h_ff) > MAX_HEIGHT) eff_h = RW'(MAX_HEIGHT);
      else eff_h = RW'(cfg_h_ff);
      ws_clip = (32'(cfg_ws_ff) > MAX_WINDOW) ? WsW'(MAX_WINDOW) : cfg_ws_ff;
      half    = HalfW'(ws_clip >> 1);
      lag     = LW'(LW'(half) * LW'(eff_w)) + LW'(half);
   end

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign acc       = req_tvalid && req_tready;
   assign push_ok   = acc && (req_tuser == OP_PUSH) && (in_row_ff < eff_h);
   assign drain_ok  = acc && !push_ok && (in_row_ff >= eff_h) && (emit_row_ff < eff_h);
   assign start_sum = (push_ok && (KW'(kcnt_ff) >= KW'(lag))) || drain_ok;
   assign ld        = (state_ff == ST_OUT) && (!rsp_vld_ff || rsp_tready);
   assign last_pos  = (emit_row_ff == eff_h - 1'b1)
                   && ((EW)'(emit_col_ff) == eff_w - 1'b1);
   assign clear_pos = (csr_acc && (csr_index != CSR_SPARE)) || (ld && last_pos);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start_sum) state_in = ST_SUM;
         ST_SUM:  if (r_ff == r1_ff && c_ff == c1_ff) state_in = ST_FIN;
         ST_FIN:  state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (ld) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mem_we     = push_ok;
   end

   // datapath
   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      kcnt_in     = kcnt_ff;
      r_in  = r_ff;
      r1_in = r1_ff;
      c_in  = c_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      sum_in = sum_ff + (rdv_ff ? SumW'(mem_q_ff) : '0);
      cnt_in = cnt_ff;
      row_hi = (RW + 1)'(emit_row_ff) + (RW + 1)'(half);
      col_hi = (EW + 1)'(emit_col_ff) + (EW + 1)'(half);
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;

      if (push_ok) begin
         kcnt_in = kcnt_ff + 1'b1;
         if ((EW)'(in_col_ff) == eff_w - 1'b1) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      if (start_sum) begin
         r_in  = (emit_row_ff >= RW'(half)) ? emit_row_ff - RW'(half) : '0;
         r1_in = (row_hi < (RW + 1)'(eff_h)) ? RW'(row_hi) : eff_h - 1'b1;
         c0_in = (emit_col_ff >= CW'(half)) ? emit_col_ff - CW'(half) : '0;
         c_in  = c0_in;
         c1_in = (col_hi < (EW + 1)'(eff_w)) ? CW'(col_hi) : CW'(eff_w - 1'b1);
         sum_in = '0;
         cnt_in = '0;
      end else if (state_ff == ST_SUM) begin
         cnt_in = cnt_ff + 1'b1;
         if (c_ff == c1_ff) begin
            c_in = c0_ff;
            r_in = r_ff + 1'b1;
         end else begin
            c_in = c_ff + 1'b1;
         end
      end

      if (ld) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {2'b00, ColW'(emit_col_ff), RowW'(emit_row_ff), div_q};
         rsp_last_in = last_pos;
         if (emit_col_ff == CW'(eff_w - 1'b1)) begin
            emit_col_in = '0;
            emit_row_in = emit_row_ff + 1'b1;
         end else begin
            emit_col_in = emit_col_ff + 1'b1;
         end
      end

      if (clear_pos) begin
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
         kcnt_in     = '0;
      end
   end

   assign waddr = {in_row_ff[SB-1:0], in_col_ff};
   assign raddr = {r_ff[SB-1:0], c_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= req_tdata;
      end
      mem_q_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cfg_ws_ff   <= WsW'(3);
         cfg_w_ff    <= ImwW'(512);
         cfg_h_ff    <= ImhW'(512);
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
         kcnt_ff     <= '0;
         rdv_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
         kcnt_ff     <= kcnt_in;
         rdv_ff      <= (state_ff == ST_SUM);
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_acc) begin
            unique case (csr_index)
               CSR_WINDOW_SIZE:  cfg_ws_ff <= csr_data[WsW-1:0];
               CSR_IMAGE_WIDTH:  cfg_w_ff  <= csr_data[ImwW-1:0];
               CSR_IMAGE_HEIGHT: cfg_h_ff  <= csr_data[ImhW-1:0];
               default: ;
            endcase
         end
      end
      r_ff        <= r_in;
      r1_ff       <= r1_in;
      c_ff        <= c_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   swmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_FIN),
      .dividend (sum_in),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_behind: assert property (@(posedge clock) disable iff (reset)
      (emit_row_ff < in_row_ff) || (emit_row_ff == in_row_ff && emit_col_ff <= in_col_ff))
      else $error("result position ahead of input position");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != '0))
      else $error("window count is zero at divide");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (EW'(in_col_ff) < eff_w) && (EW'(emit_col_ff) < eff_w))
      else $error("column position beyond image width");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_tready) |=> ($stable(rsp_data_ff) || !$past(state_ff == ST_OUT)))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

### dv/tb.sv
// testbench for sliding_window_mean_filter_core: random and directed pixel and drain
// requests, with the window mean predicted in a scoreboard class
// depends on swmf_pkg and the design files
`default_nettype none
module tb
   import swmf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [7:0]  mean;
      bit [11:0] row;
      bit [9:0]  col;
      bit        last;
   } mean_result_type;

   class mean_scoreboard;
      bit [7:0]        pixel_rows [16*1024];
      int unsigned     win_size, img_w, img_h;
      int unsigned     in_row, in_col, emit_row, emit_col;
      mean_result_type expected_means [$];
      int              errors;

      function new();
         win_size = 3;
         img_w = 512;
         img_h = 512;
         clear_frame();
      endfunction

      function void clear_frame();
         in_row = 0;
         in_col = 0;
         emit_row = 0;
         emit_col = 0;
      endfunction

      function int unsigned width_eff();
         return (img_w < 1) ? 1 : (img_w > 1024) ? 1024 : img_w;
      endfunction

      function int unsigned height_eff();
         return (img_h < 1) ? 1 : (img_h > 4096) ? 4096 : img_h;
      endfunction

      function int unsigned half();
         return win_size / 2;
      endfunction

      function bit flushing();
         return in_row >= height_eff() && emit_row < height_eff();
      endfunction

      function void write_reg(csr_index_type idx, bit [CsrW-1:0] value);
         case (idx)
            CSR_WINDOW_SIZE:  win_size = value[3:0];
            CSR_IMAGE_WIDTH:  img_w = value[10:0];
            CSR_IMAGE_HEIGHT: img_h = value[12:0];
            default:          return;
         endcase
         clear_frame();
      endfunction

      function void emit_mean();
         int unsigned w, ht, h, r0, r1, c0, c1, sum, cnt;
         mean_result_type res;
         w = width_eff();
         ht = height_eff();
         h = half();
         r0 = (emit_row >= h) ? emit_row - h : 0;
         r1 = (emit_row + h < ht) ? emit_row + h : ht - 1;
         c0 = (emit_col >= h) ? emit_col - h : 0;
         c1 = (emit_col + h < w) ? emit_col + h : w - 1;
         sum = 0;
         cnt = 0;
         for (int unsigned r = r0; r <= r1; r++) begin
            for (int unsigned c = c0; c <= c1; c++) begin
               sum += pixel_rows[(r % 16) * 1024 + c];
               cnt++;
            end
         end
         res.mean = 8'(sum / cnt);
         res.row = 12'(emit_row);
         res.col = 10'(emit_col);
         res.last = (emit_row == ht - 1) && (emit_col == w - 1);
         expected_means.push_back(res);
         if (res.last) begin
            clear_frame();
         end else begin
            emit_col++;
            if (emit_col >= w) begin
               emit_col = 0;
               emit_row++;
            end
         end
      endfunction

      function void note_request(opcode_type op, bit [7:0] pix);
         int unsigned w, h, k;
         w = width_eff();
         h = half();
         if (op == OP_DRAIN || in_row >= height_eff()) begin
            if (flushing()) emit_mean();
            return;
         end
         pixel_rows[(in_row % 16) * 1024 + in_col] = pix;
         k = in_row * w + in_col;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (k >= h * w + h) emit_mean();
      endfunction

      function void check_response(bit [31:0] data, bit last);
         mean_result_type exp_r;
         if (expected_means.size() == 0) begin
            $error("unexpected result: data %h last %0d", data, last);
            errors++;
            return;
         end
         exp_r = expected_means.pop_front();
         if (data[7:0] != exp_r.mean) begin
            $error("mean: expected %0d actual %0d", exp_r.mean, data[7:0]);
            errors++;
         end
         if (data[19:8] != exp_r.row) begin
            $error("out_row: expected %0d actual %0d", exp_r.row, data[19:8]);
            errors++;
         end
         if (data[29:20] != exp_r.col) begin
            $error("out_col: expected %0d actual %0d", exp_r.col, data[29:20]);
            errors++;
         end
         if (last != exp_r.last) begin
            $error("frame_last: expected %0d actual %0d", exp_r.last, last);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [7:0]      req_tdata = '0;
   logic            req_tuser = 1'b0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [31:0]     rsp_tdata;
   logic            rsp_tlast;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [CsrW-1:0] csr_data = '0;

   mean_scoreboard sb = new();
   int             burst_left = 0;
   int             items_sent = 0;
   int             rsp_mode = 0;
   int             rsp_cycle = 0;

   sliding_window_mean_filter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
      rsp_cycle++;
      if (rsp_cycle % 64 == 0) rsp_mode = $urandom_range(0, 3);
      case (rsp_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (rsp_cycle % 4 == 0);
         default: rsp_tready <= (rsp_cycle % 32 >= 20);
      endcase
   end

   task automatic send_request(opcode_type op, bit [7:0] pix);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, pix);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_means.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [CsrW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   function automatic bit [7:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_frame(bit partial);
      int unsigned n, stop;
      n = sb.width_eff() * sb.height_eff();
      stop = partial ? $urandom_range(0, n - 1) : n;
      for (int unsigned i = 0; i < stop; i++) begin
         if ($urandom_range(0, 9) == 0) send_request(OP_DRAIN, rand_pixel());
         send_request(OP_PUSH, rand_pixel());
      end
      if (partial) return;
      while (sb.flushing()) begin
         if ($urandom_range(0, 6) == 0) send_request(OP_PUSH, rand_pixel());
         else send_request(OP_DRAIN, rand_pixel());
      end
      repeat ($urandom_range(0, 2)) send_request(OP_DRAIN, rand_pixel());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: widest clipped image with no lag, then single pixel frame
      write_csr(CSR_WINDOW_SIZE, 13'd0);
      write_csr(CSR_IMAGE_WIDTH, 13'd2047);
      write_csr(CSR_IMAGE_HEIGHT, 13'd8191);
      send_request(OP_PUSH, 8'd255);
      send_request(OP_PUSH, 8'd0);
      send_request(OP_DRAIN, 8'd0);
      wait_idle();
      write_csr(CSR_WINDOW_SIZE, 13'd15);
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      write_csr(CSR_IMAGE_HEIGHT, 13'd0);
      send_request(OP_PUSH, 8'd170);
      send_request(OP_DRAIN, 8'd0);
      send_request(OP_DRAIN, 8'd0);
      wait_idle();
      write_csr(CSR_WINDOW_SIZE, 13'd3);
      write_csr(CSR_IMAGE_WIDTH, 13'd2);
      write_csr(CSR_IMAGE_HEIGHT, 13'd2);
      write_csr(CSR_SPARE, 13'h1fff);
      send_request(OP_DRAIN, 8'd0);
      send_request(OP_PUSH, 8'd255);
      send_request(OP_PUSH, 8'd1);
      send_request(OP_PUSH, 8'd128);
      send_request(OP_PUSH, 8'd0);
      send_request(OP_DRAIN, 8'd0);
      send_request(OP_PUSH, 8'd77);
      send_request(OP_DRAIN, 8'd0);
      send_request(OP_DRAIN, 8'd0);
      wait_idle();

      write_csr(CSR_IMAGE_WIDTH, 13'd1024);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4096);
      write_csr(CSR_WINDOW_SIZE, 13'd1);
      repeat (20) send_request(OP_PUSH, rand_pixel());
      wait_idle();

      items_sent = 0;
      while (items_sent < 750) begin
         if ($urandom_range(0, 2) != 0) begin
            write_csr(CSR_WINDOW_SIZE, CsrW'($urandom_range(0, 15)));
         end
         if ($urandom_range(0, 1) != 0) begin
            write_csr(CSR_IMAGE_WIDTH,
                      ($urandom_range(0, 3) == 0) ? CsrW'($urandom_range(13, 30))
                                                  : CsrW'($urandom_range(1, 12)));
         end
         if ($urandom_range(0, 1) != 0) begin
            write_csr(CSR_IMAGE_HEIGHT, CsrW'($urandom_range(1, 8)));
         end
         repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 5) == 0);
         wait_idle();
      end

      wait_idle();
      if (sb.errors == 0 && sb.expected_means.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
design/swmf_pkg.sv
design/swmf_div.sv
design/sliding_window_mean_filter_core.sv
dv/tb.sv
